@@ rtl/core/sms_pkg.sv @@
`timescale 1ns / 1ps

package sms_pkg;

    // Command codes carried in the cmd field of an input item
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    localparam int VALUE_W = 32;
    localparam int INDEX_W = 2;

    typedef struct packed {
        logic                       cmd;
        logic [INDEX_W-1:0]         row_index;
        logic [INDEX_W-1:0]         col_index;
        logic signed [VALUE_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        logic found;
    } out_item_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOPLEFT,
        ST_BOTRIGHT,
        ST_WALK,
        ST_FINISH
    } state_t;

    // Which matrix entry the datapath reads next
    typedef enum logic [1:0] {
        ADDR_TL,
        ADDR_BR,
        ADDR_START,
        ADDR_STEP
    } addr_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic      mem_wr;
        logic      load_key;
        addr_sel_t addr_sel;
        logic      walk_init;
        logic      walk_step;
        logic      res_set;
        logic      res_val;
        logic      load_out;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic key_lt;
        logic key_gt;
        logic row_last;
        logic col_first;
        logic out_free;
    } dp_status_t;

endpackage

@@ rtl/core/sms_stream_if.sv @@
`timescale 1ns / 1ps

interface sms_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/core/sms_ctrl.sv @@
`timescale 1ns / 1ps

module sms_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_cmd,
    output logic                in_ready,
    input  sms_pkg::dp_status_t sts,
    output sms_pkg::ctrl_cmd_t  cmd
);

    sms_pkg::state_t state_reg;
    sms_pkg::state_t state_next;

    logic key_eq;
    logic walk_miss;

    assign key_eq    = !sts.key_lt && !sts.key_gt;
    assign walk_miss = (sts.key_gt && sts.row_last) || (sts.key_lt && sts.col_first);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sms_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sms_pkg::ST_IDLE:
            begin
                if (in_valid && in_cmd == sms_pkg::CMD_SEARCH)
                begin
                    state_next = sms_pkg::ST_TOPLEFT;
                end
            end
            sms_pkg::ST_TOPLEFT:
            begin
                state_next = sts.key_lt ? sms_pkg::ST_FINISH : sms_pkg::ST_BOTRIGHT;
            end
            sms_pkg::ST_BOTRIGHT:
            begin
                state_next = sts.key_gt ? sms_pkg::ST_FINISH : sms_pkg::ST_WALK;
            end
            sms_pkg::ST_WALK:
            begin
                if (key_eq || walk_miss)
                begin
                    state_next = sms_pkg::ST_FINISH;
                end
            end
            sms_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = sms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sms_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.addr_sel  = sms_pkg::ADDR_TL;
        unique case (state_reg)
            sms_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_cmd == sms_pkg::CMD_WRITE)
                    begin
                        cmd.mem_wr = 1'b1;
                    end
                    else
                    begin
                        cmd.load_key = 1'b1;
                        cmd.addr_sel = sms_pkg::ADDR_TL;
                    end
                end
            end
            sms_pkg::ST_TOPLEFT:
            begin
                // key below the smallest entry: miss
                if (sts.key_lt)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_val = 1'b0;
                end
                else
                begin
                    cmd.addr_sel = sms_pkg::ADDR_BR;
                end
            end
            sms_pkg::ST_BOTRIGHT:
            begin
                // key above the largest entry: miss
                if (sts.key_gt)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_val = 1'b0;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    cmd.addr_sel  = sms_pkg::ADDR_START;
                end
            end
            sms_pkg::ST_WALK:
            begin
                if (key_eq)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_val = 1'b1;
                end
                else if (walk_miss)
                begin
                    cmd.res_set = 1'b1;
                    cmd.res_val = 1'b0;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    cmd.addr_sel  = sms_pkg::ADDR_STEP;
                end
            end
            sms_pkg::ST_FINISH:
            begin
                cmd.load_out = sts.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Assertions
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == sms_pkg::ST_IDLE)
        else $error("input taken outside idle");

    a_finish_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != sms_pkg::ST_FINISH && state_next == sms_pkg::ST_FINISH |-> cmd.res_set)
        else $error("search ended without a result");

    a_step_not_at_edge: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> !walk_miss && !key_eq)
        else $error("walk stepped past the matrix edge");

endmodule

@@ rtl/core/sms_dpath.sv @@
`timescale 1ns / 1ps

module sms_dpath #(
    parameter int DIM = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sms_pkg::in_item_t   in_item,
    input  sms_pkg::ctrl_cmd_t  cmd,
    output sms_pkg::dp_status_t sts,
    output logic                out_valid,
    output sms_pkg::out_item_t  out_item,
    input  logic                out_ready
);

    localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam logic [IW-1:0] LAST = IW'(DIM - 1);

    logic signed [sms_pkg::VALUE_W-1:0] mem_reg [DIM][DIM];
    logic signed [sms_pkg::VALUE_W-1:0] rd_data_reg;
    logic signed [sms_pkg::VALUE_W-1:0] key_reg;
    logic [IW-1:0] row_reg;
    logic [IW-1:0] col_reg;
    logic          res_reg;
    logic          out_valid_reg;
    logic          out_found_reg;

    logic [IW-1:0] row_step;
    logic [IW-1:0] col_step;
    logic [IW-1:0] rd_row;
    logic [IW-1:0] rd_col;
    logic [IW-1:0] wr_row;
    logic [IW-1:0] wr_col;
    logic          wr_in_range;

    // Write address check; indexes at or above DIM are dropped
    assign wr_in_range = (32'(in_item.row_index) < 32'(DIM))
                      && (32'(in_item.col_index) < 32'(DIM));
    assign wr_row = IW'(in_item.row_index);
    assign wr_col = IW'(in_item.col_index);

    // Compare key against the entry read last cycle
    assign sts.key_lt    = key_reg < rd_data_reg;
    assign sts.key_gt    = key_reg > rd_data_reg;
    assign sts.row_last  = row_reg == LAST;
    assign sts.col_first = col_reg == '0;
    assign sts.out_free  = !out_valid_reg || out_ready;

    // One staircase move: down on larger key, left on smaller
    assign row_step = sts.key_gt ? row_reg + IW'(1) : row_reg;
    assign col_step = sts.key_lt ? col_reg - IW'(1) : col_reg;

    // Read address select
    always_comb
    begin
        case (cmd.addr_sel)
            sms_pkg::ADDR_TL:
            begin
                rd_row = '0;
                rd_col = '0;
            end
            sms_pkg::ADDR_BR:
            begin
                rd_row = LAST;
                rd_col = LAST;
            end
            sms_pkg::ADDR_START:
            begin
                rd_row = '0;
                rd_col = LAST;
            end
            default:
            begin
                rd_row = row_step;
                rd_col = col_step;
            end
        endcase
    end

    // Matrix memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr && wr_in_range)
        begin
            mem_reg[wr_row][wr_col] <= in_item.value;
        end
        rd_data_reg <= mem_reg[rd_row][rd_col];
    end

    // Key, walk position, search result and output value
    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= in_item.value;
        end
        if (cmd.walk_init)
        begin
            row_reg <= '0;
            col_reg <= LAST;
        end
        else if (cmd.walk_step)
        begin
            row_reg <= row_step;
            col_reg <= col_step;
        end
        if (cmd.res_set)
        begin
            res_reg <= cmd.res_val;
        end
        if (cmd.load_out)
        begin
            out_found_reg <= res_reg;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_item.found = out_found_reg;

    // Assertions
    a_step_down: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step && sts.key_gt |=> row_reg == $past(row_reg) + IW'(1)
                                     && col_reg == $past(col_reg))
        else $error("down move did not advance the row");

    a_step_left: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step && sts.key_lt |=> col_reg == $past(col_reg) - IW'(1)
                                     && row_reg == $past(row_reg))
        else $error("left move did not retreat the column");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !out_valid_reg || out_ready)
        else $error("result overwrote an untaken item");

    a_load_value: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg && out_found_reg == $past(res_reg))
        else $error("result register not loaded");

endmodule

@@ rtl/core/sorted_matrix_staircase_search_top.sv @@
`timescale 1ns / 1ps

// Staircase search over a DIM x DIM matrix with sorted rows and columns.
// Channels: req carries input items (cmd, row_index, col_index, value);
// rsp carries one item (found) per search. Both use valid/ready.
// A write item (cmd 0) stores value at row_index/col_index and gives no
// result; writes outside the matrix are dropped.
// A search item (cmd 1) checks the key against the top-left and bottom-right
// entries, then walks from the top-right corner one entry per cycle, each
// step one registered read of the matrix memory.
// A key below the top-left entry or above the bottom-right entry ends the
// search without a walk; otherwise the walk makes 1 to 2*DIM-1 reads.
// The next item is taken the cycle after the result is placed in the
// output register. Writes are taken one per cycle while idle; no item is
// taken while a search is in progress.
// The output register holds a finished result while rsp stalls; new items
// (writes and the start of a search) are still taken, and a finished search
// waits only if the previous result has not yet been taken.
// Reset clears the controller and the output valid; matrix contents are
// undefined until written.
module sorted_matrix_staircase_search_top #(
    parameter int DIM = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    sms_stream_if.sink      req,
    sms_stream_if.source    rsp
);

    sms_pkg::in_item_t   in_item;
    sms_pkg::out_item_t  out_item;
    sms_pkg::ctrl_cmd_t  cmd;
    sms_pkg::dp_status_t sts;
    logic                in_ready;
    logic                out_valid;

    assign in_item     = req.payload;
    assign req.ready   = in_ready;
    assign rsp.valid   = out_valid;
    assign rsp.payload = out_item;

    sms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_cmd   (in_item.cmd),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sms_dpath #(
        .DIM (DIM)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_item  (out_item),
        .out_ready (rsp.ready)
    );

endmodule
